### hdl/gdd_pkg.sv
// ----------------------------------------------------------------------------
// gdd_pkg - shared definitions for the Gregorian date difference core
// Field widths, year clamp, reciprocal constants for the constant divisions,
// the month offset table and the stage enable bundle.
// ----------------------------------------------------------------------------
package gdd_pkg;

	// Input field widths
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;

	// Years above this limit are clamped to it
	localparam int MAX_YEAR = 9999;

	// Day number of a clamped date, counted from 1 Jan of year 1
	localparam int DN_W = 22;

	// Output field widths
	localparam int DAYS_W    = 23;
	localparam int YEARS_W   = 15;
	localparam int HOURS_W   = 28;
	localparam int MINUTES_W = 34;
	localparam int SECONDS_W = 40;
	localparam int WEEKS_W   = 20;
	localparam int LEFT_W    = 4;

	// Stream word widths, padded to whole bytes
	localparam int IN_W  = 48;
	localparam int OUT_W = 168;

	// Reciprocal multipliers: q = (x * MUL) >> SHIFT
	localparam int DIV100_MUL   = 5243;     // exact for x < 43690
	localparam int DIV100_SHIFT = 19;
	localparam int DIV7_MUL     = 4793490;  // floor(2^25 / 7), may be one low
	localparam int DIV7_SHIFT   = 25;
	localparam int DIV365_MUL   = 2941758;  // floor(2^30 / 365), may be one low
	localparam int DIV365_SHIFT = 30;

	// Width of the day-of-year sum (offset + day + leap day)
	localparam int PART_W = 9;

	// Advance strobes for the three day number stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} gdd_stage_en_t;

	// Days in the year before the first of the month (month index 0 = January)
	function automatic logic [PART_W-1:0] days_before_month(input logic [MONTH_W-1:0] idx);
		logic [PART_W-1:0] res;
		case (idx)
			4'd0:    res = 9'd0;
			4'd1:    res = 9'd31;
			4'd2:    res = 9'd59;
			4'd3:    res = 9'd90;
			4'd4:    res = 9'd120;
			4'd5:    res = 9'd151;
			4'd6:    res = 9'd181;
			4'd7:    res = 9'd212;
			4'd8:    res = 9'd243;
			4'd9:    res = 9'd273;
			4'd10:   res = 9'd304;
			4'd11:   res = 9'd334;
			default: res = 9'd0;
		endcase
		return res;
	endfunction

endpackage

### hdl/gdd_day_num.sv
// ----------------------------------------------------------------------------
// gdd_day_num - date to day number, three pipeline stages
// Clamps month and year, then forms 365*py + py/4 - py/100 + py/400 plus the
// day of year, with py the number of whole years before the date.
// ----------------------------------------------------------------------------
module gdd_day_num (
	input  logic                         clk,
	input  gdd_pkg::gdd_stage_en_t       en,
	input  logic [gdd_pkg::DAY_W-1:0]    day,
	input  logic [gdd_pkg::MONTH_W-1:0]  month,
	input  logic [gdd_pkg::YEAR_W-1:0]   year,
	output logic [gdd_pkg::DN_W-1:0]     day_num
);
	import gdd_pkg::*;

	localparam int MUL100_W = $clog2(DIV100_MUL + 1);
	localparam int PROD_W   = YEAR_W + MUL100_W;
	localparam int Q100_W   = PROD_W - DIV100_SHIFT;
	localparam int MONTHS   = 12;

	// Stage 1: clamp, whole years before the date, start of divide by 100
	logic [YEAR_W-1:0]  year_c;
	logic [YEAR_W-1:0]  py_c;
	logic [MONTH_W-1:0] midx_c;

	always_comb begin
		if (year == '0) begin
			year_c = YEAR_W'(1);
		end else if (int'(year) > MAX_YEAR) begin
			year_c = YEAR_W'(MAX_YEAR);
		end else begin
			year_c = year;
		end
		py_c = year_c - YEAR_W'(1);
		if (month == '0) begin
			midx_c = '0;
		end else if (int'(month) > MONTHS) begin
			midx_c = MONTH_W'(MONTHS - 1);
		end else begin
			midx_c = month - MONTH_W'(1);
		end
	end

	logic [YEAR_W-1:0]  py_s1;
	logic [MONTH_W-1:0] midx_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [PROD_W-1:0]  prod_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			py_s1   <= py_c;
			midx_s1 <= midx_c;
			day_s1  <= day;
			prod_s1 <= PROD_W'(py_c) * PROD_W'(DIV100_MUL);
		end
	end

	// Stage 2: century count, leap test, day of year, 365 * py
	logic [Q100_W-1:0] q100_c;
	logic [YEAR_W-1:0] r100_c;
	logic              leap_c;
	logic [PART_W-1:0] part_c;

	always_comb begin
		q100_c = prod_s1[PROD_W-1:DIV100_SHIFT];
		r100_c = py_s1 - YEAR_W'(YEAR_W'(q100_c) * YEAR_W'(100));
		// year % 4 == 0 and (year % 100 != 0 or year % 400 == 0), seen through py
		leap_c = (py_s1[1:0] == 2'b11) &&
		         ((r100_c != YEAR_W'(99)) || (q100_c[1:0] == 2'b11));
		part_c = days_before_month(midx_s1) + PART_W'(day_s1) +
		         PART_W'(leap_c && (midx_s1 >= MONTH_W'(2)));
	end

	logic [DN_W-1:0]     py365_s2;
	logic [YEAR_W-3:0]   py4_s2;
	logic [Q100_W-1:0]   q100_s2;
	logic [PART_W-1:0]   part_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			py365_s2 <= DN_W'(py_s1) * DN_W'(365);
			py4_s2   <= py_s1[YEAR_W-1:2];
			q100_s2  <= q100_c;
			part_s2  <= part_c;
		end
	end

	// Stage 3: sum the terms
	logic [DN_W-1:0] day_num_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			day_num_s3 <= py365_s2 + DN_W'(py4_s2) - DN_W'(q100_s2) +
			              DN_W'(q100_s2[Q100_W-1:2]) + DN_W'(part_s2);
		end
	end

	assign day_num = day_num_s3;

endmodule

### hdl/gregorian_date_difference_core.sv
// ----------------------------------------------------------------------------
// gregorian_date_difference_core - signed days between two Gregorian dates
// Converts both dates to day numbers, subtracts, and derives whole years,
// hours, minutes, seconds, whole weeks and leftover days.
// ----------------------------------------------------------------------------
//  Channel   Dir  Width  Word contents (lowest bits first)
//  s_*       in   48     start_day, start_month, start_year,
//                        end_day, end_month, end_year
//  m_*       out  168    total_days, whole_years, total_hours, total_minutes,
//                        total_seconds, whole_weeks, leftover_days
//
//  Seven stages (day numbers over three, subtract, products and quotient
//  estimates, quotient fix, sign restore); one word is taken per cycle unless
//  every stage is full and the output is stalled; results leave from stage 7.
//  arst_n clears all stage valid bits; data registers are not reset.
//  A stalled output holds its word; upstream stages keep filling empty slots
//  and stop only when the stage ahead of them is full and held.
// ----------------------------------------------------------------------------
module gregorian_date_difference_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// start_day, start_month, start_year, end_day, end_month, end_year
	input  logic [gdd_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// total_days, whole_years, total_hours, total_minutes, total_seconds,
	// whole_weeks, leftover_days
	output logic [gdd_pkg::OUT_W-1:0]   m_tdata
);
	import gdd_pkg::*;

	localparam int SD_LO = 0;
	localparam int SM_LO = SD_LO + DAY_W;
	localparam int SY_LO = SM_LO + MONTH_W;
	localparam int ED_LO = SY_LO + YEAR_W;
	localparam int EM_LO = ED_LO + DAY_W;
	localparam int EY_LO = EM_LO + MONTH_W;

	localparam int MUL7_W   = $clog2(DIV7_MUL + 1);
	localparam int MUL365_W = $clog2(DIV365_MUL + 1);
	localparam int P7_W     = DN_W + MUL7_W;
	localparam int P365_W   = DN_W + MUL365_W;
	localparam int Q7_W     = P7_W - DIV7_SHIFT;
	localparam int Q365_W   = P365_W - DIV365_SHIFT;
	localparam int R7_W     = 3;
	localparam int PAD_W    = OUT_W - DAYS_W - YEARS_W - HOURS_W - MINUTES_W -
	                          SECONDS_W - WEEKS_W - LEFT_W;
	localparam int CHK_W    = DAYS_W + 1;

	// Stage valid bits and advance strobes
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic en4, en5, en6, en7;
	gdd_stage_en_t dn_en;

	assign en7      = ~valid_s7 | m_tready;
	assign en6      = ~valid_s6 | en7;
	assign en5      = ~valid_s5 | en6;
	assign en4      = ~valid_s4 | en5;
	assign dn_en.s3 = ~valid_s3 | en4;
	assign dn_en.s2 = ~valid_s2 | dn_en.s3;
	assign dn_en.s1 = ~valid_s1 | dn_en.s2;
	assign s_tready = dn_en.s1;
	assign m_tvalid = valid_s7;

	// Advance valid bits where the stage moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (dn_en.s1) valid_s1 <= s_tvalid;
			if (dn_en.s2) valid_s2 <= valid_s1;
			if (dn_en.s3) valid_s3 <= valid_s2;
			if (en4)      valid_s4 <= valid_s3;
			if (en5)      valid_s5 <= valid_s4;
			if (en6)      valid_s6 <= valid_s5;
			if (en7)      valid_s7 <= valid_s6;
		end
	end

	// Stages 1 to 3: day numbers of both dates
	logic [DN_W-1:0] dn_start, dn_end;

	gdd_day_num u_dn_start (
		.clk     (clk),
		.en      (dn_en),
		.day     (s_tdata[SM_LO-1:SD_LO]),
		.month   (s_tdata[SY_LO-1:SM_LO]),
		.year    (s_tdata[ED_LO-1:SY_LO]),
		.day_num (dn_start)
	);

	gdd_day_num u_dn_end (
		.clk     (clk),
		.en      (dn_en),
		.day     (s_tdata[EM_LO-1:ED_LO]),
		.month   (s_tdata[EY_LO-1:EM_LO]),
		.year    (s_tdata[EY_LO+YEAR_W-1:EY_LO]),
		.day_num (dn_end)
	);

	// Stage 4: signed difference and its magnitude
	logic signed [DAYS_W-1:0] days_c;
	logic [DN_W-1:0]          mag_c;

	always_comb begin
		days_c = $signed({1'b0, dn_end}) - $signed({1'b0, dn_start});
		mag_c  = days_c[DAYS_W-1] ? (dn_start - dn_end) : (dn_end - dn_start);
	end

	logic signed [DAYS_W-1:0] days_s4;
	logic [DN_W-1:0]          mag_s4;
	logic                     neg_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			days_s4 <= days_c;
			mag_s4  <= mag_c;
			neg_s4  <= days_c[DAYS_W-1];
		end
	end

	// Stage 5: time unit products and reciprocal quotient estimates
	logic [P7_W-1:0]   p7_c;
	logic [P365_W-1:0] p365_c;

	assign p7_c   = P7_W'(mag_s4) * P7_W'(DIV7_MUL);
	assign p365_c = P365_W'(mag_s4) * P365_W'(DIV365_MUL);

	logic signed [DAYS_W-1:0]    days_s5;
	logic signed [HOURS_W-1:0]   hours_s5;
	logic signed [MINUTES_W-1:0] minutes_s5;
	logic signed [SECONDS_W-1:0] seconds_s5;
	logic [DN_W-1:0]             mag_s5;
	logic                        neg_s5;
	logic [Q7_W-1:0]             q7_s5;
	logic [Q365_W-1:0]           q365_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			days_s5    <= days_s4;
			hours_s5   <= HOURS_W'(days_s4) * HOURS_W'(24);
			minutes_s5 <= MINUTES_W'(days_s4) * MINUTES_W'(1440);
			seconds_s5 <= SECONDS_W'(days_s4) * SECONDS_W'(86400);
			mag_s5     <= mag_s4;
			neg_s5     <= neg_s4;
			q7_s5      <= p7_c[P7_W-1:DIV7_SHIFT];
			q365_s5    <= p365_c[P365_W-1:DIV365_SHIFT];
		end
	end

	// Stage 6: correct quotients that came out one low
	logic [DN_W-1:0]   r7_c, r365_c;
	logic [Q7_W-1:0]   q7_fix_c;
	logic [R7_W-1:0]   r7_fix_c;
	logic [Q365_W-1:0] q365_fix_c;

	always_comb begin
		r7_c   = mag_s5 - DN_W'(DN_W'(q7_s5) * DN_W'(7));
		r365_c = mag_s5 - DN_W'(DN_W'(q365_s5) * DN_W'(365));
		if (r7_c >= DN_W'(7)) begin
			q7_fix_c = q7_s5 + Q7_W'(1);
			r7_fix_c = R7_W'(r7_c - DN_W'(7));
		end else begin
			q7_fix_c = q7_s5;
			r7_fix_c = R7_W'(r7_c);
		end
		if (r365_c >= DN_W'(365)) begin
			q365_fix_c = q365_s5 + Q365_W'(1);
		end else begin
			q365_fix_c = q365_s5;
		end
	end

	logic signed [DAYS_W-1:0]    days_s6;
	logic signed [HOURS_W-1:0]   hours_s6;
	logic signed [MINUTES_W-1:0] minutes_s6;
	logic signed [SECONDS_W-1:0] seconds_s6;
	logic                        neg_s6;
	logic [Q7_W-1:0]             weeks_mag_s6;
	logic [R7_W-1:0]             left_mag_s6;
	logic [Q365_W-1:0]           years_mag_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			days_s6      <= days_s5;
			hours_s6     <= hours_s5;
			minutes_s6   <= minutes_s5;
			seconds_s6   <= seconds_s5;
			neg_s6       <= neg_s5;
			weeks_mag_s6 <= q7_fix_c;
			left_mag_s6  <= r7_fix_c;
			years_mag_s6 <= q365_fix_c;
		end
	end

	// Stage 7: restore the sign of quotient and remainder, hold the output word
	logic signed [DAYS_W-1:0]    days_s7;
	logic signed [YEARS_W-1:0]   years_s7;
	logic signed [HOURS_W-1:0]   hours_s7;
	logic signed [MINUTES_W-1:0] minutes_s7;
	logic signed [SECONDS_W-1:0] seconds_s7;
	logic signed [WEEKS_W-1:0]   weeks_s7;
	logic signed [LEFT_W-1:0]    left_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			days_s7    <= days_s6;
			hours_s7   <= hours_s6;
			minutes_s7 <= minutes_s6;
			seconds_s7 <= seconds_s6;
			if (neg_s6) begin
				years_s7 <= -YEARS_W'(years_mag_s6);
				weeks_s7 <= -WEEKS_W'(weeks_mag_s6);
				left_s7  <= -LEFT_W'(left_mag_s6);
			end else begin
				years_s7 <= YEARS_W'(years_mag_s6);
				weeks_s7 <= WEEKS_W'(weeks_mag_s6);
				left_s7  <= LEFT_W'(left_mag_s6);
			end
		end
	end

	assign m_tdata = {{PAD_W{1'b0}}, left_s7, weeks_s7, seconds_s7, minutes_s7,
	                  hours_s7, years_s7, days_s7};

	// Cross-checks between the output fields
	logic signed [CHK_W-1:0] chk_week_c, chk_year_c;

	assign chk_week_c = CHK_W'(weeks_s7) * CHK_W'(7) + CHK_W'(left_s7);
	assign chk_year_c = CHK_W'(days_s7) - CHK_W'(years_s7) * CHK_W'(365);

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted word did not reach stage 1");

	a_week_split: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> chk_week_c == CHK_W'(days_s7))
		else $error("weeks and leftover days do not add up to total days");

	a_left_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (left_s7 == '0) || (left_s7[LEFT_W-1] == days_s7[DAYS_W-1]))
		else $error("leftover days sign differs from total days");

	a_year_rem: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (chk_year_c > CHK_W'(-365)) && (chk_year_c < CHK_W'(365)))
		else $error("whole years off by at least one");

endmodule
